### hw/rtl/distance_vector_route_update_assert.svh
// Assertion macros shared by the checker files of the route update block.
// No dependencies; take it in with an include of the bare file name.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define DVRU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define DVRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dvru_pkg.sv
// Package of the distance-vector route update block: sizes, operation codes
// and the payload and control structures. No dependencies.
package dvru_pkg;

   localparam int NODE_COUNT = 256;
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int COST_BITS  = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_RELAX  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [7:0]           dest;
      logic [COST_BITS-1:0] cost_in;
      logic [7:0]           hop_in;
      logic [7:0]           neighbor;
      logic [COST_BITS-1:0] link_cost;
   } req_type;

   typedef struct packed {
      logic                 entry_valid;
      logic [COST_BITS-1:0] cost_out;
      logic [7:0]           hop_out;
      logic                 changed;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [COST_BITS-1:0] cost;
      logic [7:0]           hop;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [NODE_BITS-1:0] addr;
      logic [COST_BITS-1:0] cost;
      logic [7:0]           hop;
   } wr_type;

endpackage

### hw/rtl/dvru_channels.sv
// Handshake channels of the route update block: request, response and
// register write. Depends on dvru_pkg.
interface dvru_req_if;
   logic             valid;
   logic             ready;
   dvru_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dvru_rsp_if;
   logic             valid;
   logic             ready;
   dvru_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dvru_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/distance_vector_route_update.sv
// Distance-vector route table engine. Each request beat inserts, relaxes or
// looks up the entry of one destination node and returns exactly one response
// beat. A new request is taken every cycle unless the response side stalls.
// A taken request passes the registered read of the table memory and the
// request stage, then the response register, which holds the beat while
// the channel stalls. Back-to-back requests to the same destination see
// each other's updates. The own_node register is written through the csr
// channel, which is always ready, and resets to 0. The valid flags are cleared
// in the reset cycle itself, so no clearing pass is needed.
// Depends on dvru_pkg, the channel interfaces, dvru_table and dvru_relax.
module distance_vector_route_update (
   input  logic          clock,
   input  logic          reset,
   dvru_req_if.sink      req_chan,
   dvru_rsp_if.source    rsp_chan,
   dvru_csr_if.sink      csr_chan
);
   import dvru_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_item_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_rsp_ff;
   logic [7:0] own_node_ff;
   logic [7:0] own_node_in;
   logic      out_free;
   logic      s1_adv;
   logic      accept;
   entry_type entry;
   wr_type    rel_wr;
   wr_type    tbl_wr;
   rsp_type   rel_rsp;

   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign s1_adv        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   assign own_node_in  = csr_chan.valid ? csr_chan.data : own_node_ff;

   // The table is written only as the item leaves for the response register.
   always_comb begin
      tbl_wr    = rel_wr;
      tbl_wr.en = rel_wr.en && s1_adv;
   end

   dvru_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_chan.payload.dest[NODE_BITS-1:0]),
      .vld_addr (s1_item_ff.dest[NODE_BITS-1:0]),
      .wr       (tbl_wr),
      .entry    (entry)
   );

   dvru_relax u_relax (
      .item     (s1_item_ff),
      .entry    (entry),
      .own_node (own_node_ff),
      .wr       (rel_wr),
      .rsp      (rel_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         own_node_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         own_node_ff  <= own_node_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_chan.payload;
      end
      if (s1_adv) begin
         out_rsp_ff <= rel_rsp;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_rsp_ff;

endmodule

### hw/rtl/dvru_table.sv
// Route table storage: cost and next-hop memories with a registered read,
// valid flags in flip-flops and a bypass for a write in the read cycle. Uses dvru_pkg.
module dvru_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_en,
   input  logic [dvru_pkg::NODE_BITS-1:0]      rd_addr,
   input  logic [dvru_pkg::NODE_BITS-1:0]      vld_addr,
   input  dvru_pkg::wr_type                    wr,
   output dvru_pkg::entry_type                 entry
);
   import dvru_pkg::*;

   logic [COST_BITS-1:0]  cost_mem [NODE_COUNT];
   logic [7:0]            hop_mem [NODE_COUNT];
   logic [COST_BITS-1:0]  rd_cost_ff;
   logic [7:0]            rd_hop_ff;
   logic                  byp_ff;
   logic                  byp_in;
   logic [COST_BITS-1:0]  byp_cost_ff;
   logic [7:0]            byp_hop_ff;
   logic [NODE_COUNT-1:0] valid_ff;
   logic [NODE_COUNT-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cost_mem[wr.addr] <= wr.cost;
         hop_mem[wr.addr]  <= wr.hop;
      end
      if (rd_en) begin
         rd_cost_ff  <= cost_mem[rd_addr];
         rd_hop_ff   <= hop_mem[rd_addr];
         byp_cost_ff <= wr.cost;
         byp_hop_ff  <= wr.hop;
      end
   end

   // The memory read returns the old word when the same entry is written in
   // that cycle, so the written word is kept aside and used instead.
   assign byp_in = rd_en ? (wr.en && (wr.addr == rd_addr)) : byp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         byp_ff   <= byp_in;
      end
   end

   assign entry.valid = valid_ff[vld_addr];
   assign entry.cost  = byp_ff ? byp_cost_ff : rd_cost_ff;
   assign entry.hop   = byp_ff ? byp_hop_ff : rd_hop_ff;

endmodule

### hw/rtl/dvru_relax.sv
// Per-item update logic: insert, Bellman-Ford relax with split horizon, and
// look up, giving the table write and the response. Uses dvru_pkg.
module dvru_relax (
   input  dvru_pkg::req_type   item,
   input  dvru_pkg::entry_type entry,
   input  logic [7:0]          own_node,
   output dvru_pkg::wr_type    wr,
   output dvru_pkg::rsp_type   rsp
);
   import dvru_pkg::*;

   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   logic                 is_insert;
   logic                 is_relax;
   logic                 to_neighbor;
   logic [COST_BITS-1:0] adv_cost;
   logic [7:0]           via_hop;
   logic [COST_BITS:0]   sum;
   logic [COST_BITS-1:0] sum_sat;
   logic                 take;
   logic                 write;
   logic [COST_BITS-1:0] new_cost;
   logic [7:0]           new_hop;
   logic                 valid_after;

   always_comb begin
      is_insert   = (item.op == OP_INSERT);
      is_relax    = (item.op == OP_RELAX);
      // A neighbor reaches itself at no cost.
      to_neighbor = (item.dest == item.neighbor);
      adv_cost    = to_neighbor ? '0 : item.cost_in;
      via_hop     = to_neighbor ? item.neighbor : item.hop_in;
      sum         = {1'b0, item.link_cost} + {1'b0, adv_cost};
      sum_sat     = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
      // Take the route when it is no worse, or when the entry already runs
      // through this neighbor and the neighbor does not route back via us.
      take        = is_relax && entry.valid &&
                    ((sum_sat <= entry.cost) ||
                     ((entry.hop == item.neighbor) && (via_hop != own_node)));
      write       = is_insert || take;
      new_cost    = is_insert ? item.cost_in : sum_sat;
      new_hop     = is_insert ? item.hop_in : item.neighbor;
      valid_after = is_insert || entry.valid;

      wr.en   = write;
      wr.addr = item.dest[NODE_BITS-1:0];
      wr.cost = new_cost;
      wr.hop  = new_hop;

      rsp.entry_valid = valid_after;
      rsp.changed     = take;
      if (!valid_after) begin
         rsp.cost_out = '0;
         rsp.hop_out  = '0;
      end else if (write) begin
         rsp.cost_out = new_cost;
         rsp.hop_out  = new_hop;
      end else begin
         rsp.cost_out = entry.cost;
         rsp.hop_out  = entry.hop;
      end
   end

endmodule

### hw/rtl/dvru_checker.sv
// Port-level checks on the route update block and the bind that attaches them.
// Depends on dvru_pkg and distance_vector_route_update_assert.svh.
`include "distance_vector_route_update_assert.svh"

module dvru_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dvru_pkg::rsp_type rsp_payload
);
   import dvru_pkg::*;

   logic rsp_stall;
   logic rsp_missing;
   logic fields_zero;
   logic rsp_change;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_missing = rsp_valid && !rsp_payload.entry_valid;
   assign fields_zero = (rsp_payload.cost_out == '0) && (rsp_payload.hop_out == '0) &&
                        !rsp_payload.changed;
   assign rsp_change  = rsp_valid && rsp_payload.changed;

   `DVRU_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response beat after reset")

   `DVRU_ASSERT(a_rsp_hold, clock, reset,
      rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response beat changed")

   `DVRU_ASSERT(a_missing_zero, clock, reset,
      rsp_missing |-> fields_zero, "missing entry with nonzero fields")

   `DVRU_ASSERT(a_changed_valid, clock, reset,
      rsp_change |-> rsp_payload.entry_valid, "change reported on a missing entry")

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
